>>> rtl/lhi_pkg.sv
// Shared types, constants, saturation and microcode ROM for the Lorenz Heun integrator.
package lhi_pkg;

  // Number format: signed Q8.24
  localparam int VW = 32;
  localparam int FB = 24;
  localparam int WW = 2 * VW;
  localparam int EW = 2 * VW + 1;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [EW-1:0] ext_t;
  typedef logic [VW-2:0]        dt_t;

  // Saturation bounds at extended width
  localparam ext_t MAX_E = (EW'(1) <<< (VW - 1)) - EW'(1);
  localparam ext_t MIN_E = -(EW'(1) <<< (VW - 1));
  localparam val_t MAX_V = MAX_E[VW-1:0];
  localparam val_t MIN_V = MIN_E[VW-1:0];

  // Register reset values
  localparam val_t SIGMA_RST   = 32'sd167772160;
  localparam val_t BETA_RST    = 32'sd44739243;
  localparam val_t RHO_RST     = 32'sd335544320;
  localparam dt_t  STEP_RST    = 31'd167772;
  localparam val_t START_X_RST = 32'sd0;
  localparam val_t START_Y_RST = 32'sd0;
  localparam val_t START_Z_RST = 32'sd419430400;

  localparam logic METHOD_EULER = 1'b0;
  localparam logic METHOD_HEUN  = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SIGMA,
    REG_BETA,
    REG_RHO,
    REG_STEP,
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_METHOD
  } reg_idx_t;

  localparam int PADDR_W = 5;

  typedef struct packed {
    val_t sigma;
    val_t beta;
    val_t rho;
    dt_t  step_size;
    val_t start_x;
    val_t start_y;
    val_t start_z;
    logic method;
  } cfg_t;

  // Control state machine
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } fsm_t;

  // Shared unit operations
  typedef enum logic [2:0] {
    OP_MUL,
    OP_TAKE,
    OP_ADD,
    OP_SUB,
    OP_CORR
  } op_t;

  // Operand sources
  typedef enum logic [3:0] {
    S_NONE,
    S_CX, S_CY, S_CZ,
    S_QX, S_QY, S_QZ,
    S_T0, S_T1,
    S_D0, S_D1, S_D2,
    S_SIG, S_RHO, S_BETA, S_DT
  } src_t;

  // Result destinations
  typedef enum logic [3:0] {
    D_NONE,
    D_QX, D_QY, D_QZ,
    D_T0, D_T1,
    D_D0, D_D1, D_D2
  } dst_t;

  typedef struct packed {
    op_t        op;
    src_t       sa;
    src_t       sb;
    dst_t       dst;
    logic [1:0] wsel;
    logic       keep;
    logic       branch;
    logic       last;
  } uinst_t;

  typedef struct packed {
    val_t val;
    logic ovf;
  } sat_t;

  // Microcode layout
  localparam int PC_W        = 6;
  localparam int SLOPE_LEN   = 14;
  localparam int TAIL_LEN    = 9;
  localparam int EULER_START = SLOPE_LEN;
  localparam int HEUN_START  = SLOPE_LEN + TAIL_LEN;
  localparam int QSLOPE_START = HEUN_START + TAIL_LEN;
  localparam int CORR_START  = QSLOPE_START + SLOPE_LEN;
  localparam int UCODE_DEPTH = CORR_START + TAIL_LEN;

  typedef enum logic [1:0] {
    TAIL_EULER,
    TAIL_PRED,
    TAIL_CORR
  } tail_t;

  // Clamp an extended value into the value range
  function automatic sat_t sat_ext(ext_t v);
    sat_t r;
    if (v > MAX_E) begin
      r.val = MAX_V;
      r.ovf = 1'b1;
    end else if (v < MIN_E) begin
      r.val = MIN_V;
      r.ovf = 1'b1;
    end else begin
      r.val = v[VW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic uinst_t mk(op_t op, src_t sa, src_t sb, dst_t dst);
    uinst_t u;
    u.op     = op;
    u.sa     = sa;
    u.sb     = sb;
    u.dst    = dst;
    u.wsel   = 2'd0;
    u.keep   = 1'b0;
    u.branch = 1'b0;
    u.last   = 1'b0;
    return u;
  endfunction

  // Slope evaluation at point (px, py, pz)
  function automatic uinst_t slope_line(logic [3:0] k, src_t px, src_t py, src_t pz);
    uinst_t u;
    case (k)
      4'd0:    u = mk(OP_SUB,  py,     px,     D_T0);
      4'd1:    u = mk(OP_MUL,  S_SIG,  S_T0,   D_NONE);
      4'd2:    u = mk(OP_TAKE, S_NONE, S_NONE, D_D0);
      4'd3:    u = mk(OP_MUL,  S_RHO,  px,     D_NONE);
      4'd4:    u = mk(OP_TAKE, S_NONE, S_NONE, D_T0);
      4'd5:    u = mk(OP_MUL,  px,     pz,     D_NONE);
      4'd6:    u = mk(OP_TAKE, S_NONE, S_NONE, D_T1);
      4'd7:    u = mk(OP_SUB,  S_T0,   S_T1,   D_T0);
      4'd8:    u = mk(OP_SUB,  S_T0,   py,     D_D1);
      4'd9:    u = mk(OP_MUL,  px,     py,     D_NONE);
      4'd10:   u = mk(OP_TAKE, S_NONE, S_NONE, D_T0);
      4'd11:   u = mk(OP_MUL,  S_BETA, pz,     D_NONE);
      4'd12:   u = mk(OP_TAKE, S_NONE, S_NONE, D_T1);
      4'd13:   u = mk(OP_SUB,  S_T0,   S_T1,   D_D2);
      default: u = mk(OP_MUL,  S_NONE, S_NONE, D_NONE);
    endcase
    return u;
  endfunction

  // Position update: point plus dt*slope, or half of both products in the corrector
  function automatic uinst_t tail_line(logic [3:0] k, tail_t mode);
    uinst_t u;
    op_t    sc;
    sc = (mode == TAIL_CORR) ? OP_CORR : OP_TAKE;
    case (k)
      4'd0:    u = mk(OP_MUL, S_DT,   S_D0,   D_NONE);
      4'd1:    u = mk(sc,     S_NONE, S_NONE, D_T0);
      4'd2:    u = mk(OP_ADD, S_CX,   S_T0,   D_QX);
      4'd3:    u = mk(OP_MUL, S_DT,   S_D1,   D_NONE);
      4'd4:    u = mk(sc,     S_NONE, S_NONE, D_T0);
      4'd5:    u = mk(OP_ADD, S_CY,   S_T0,   D_QY);
      4'd6:    u = mk(OP_MUL, S_DT,   S_D2,   D_NONE);
      4'd7:    u = mk(sc,     S_NONE, S_NONE, D_T0);
      4'd8:    u = mk(OP_ADD, S_CZ,   S_T0,   D_QZ);
      default: u = mk(OP_MUL, S_NONE, S_NONE, D_NONE);
    endcase
    // in the predictor tail, each full dt*slope product is held for the corrector
    if (k == 4'd1 || k == 4'd4 || k == 4'd7) begin
      u.wsel = (k == 4'd1) ? 2'd0 : ((k == 4'd4) ? 2'd1 : 2'd2);
      u.keep = (mode == TAIL_PRED);
    end
    u.last = (k == 4'd8) && (mode != TAIL_PRED);
    return u;
  endfunction

  // Microcode ROM
  function automatic uinst_t ucode(logic [PC_W-1:0] pc);
    uinst_t u;
    if (pc < PC_W'(EULER_START)) begin
      u = slope_line(4'(pc), S_CX, S_CY, S_CZ);
      u.branch = (pc == PC_W'(SLOPE_LEN - 1));
    end else if (pc < PC_W'(HEUN_START)) begin
      u = tail_line(4'(pc - PC_W'(EULER_START)), TAIL_EULER);
    end else if (pc < PC_W'(QSLOPE_START)) begin
      u = tail_line(4'(pc - PC_W'(HEUN_START)), TAIL_PRED);
    end else if (pc < PC_W'(CORR_START)) begin
      u = slope_line(4'(pc - PC_W'(QSLOPE_START)), S_QX, S_QY, S_QZ);
    end else if (pc < PC_W'(UCODE_DEPTH)) begin
      u = tail_line(4'(pc - PC_W'(CORR_START)), TAIL_CORR);
    end else begin
      u = mk(OP_MUL, S_NONE, S_NONE, D_NONE);
      u.last = 1'b1;
    end
    return u;
  endfunction

endpackage

>>> rtl/lhi_alu.sv
// Shared arithmetic unit: registered multiplier, saturating adder and corrector.
module lhi_alu import lhi_pkg::*; (
  input  logic  clk,
  input  op_t   op,
  input  logic  mul_en,
  input  val_t  opa,
  input  val_t  opb,
  input  wide_t keep,
  output val_t  res,
  output logic  ovf,
  output wide_t prod
);

  ext_t arg;
  sat_t sat;

  // Form the full product and hold it for the following line
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= WW'(opa) * WW'(opb);
    end
  end

  // Select the exact value to clamp
  always_comb begin
    case (op)
      OP_TAKE: arg = EW'(prod) >>> FB;
      OP_ADD:  arg = EW'(opa) + EW'(opb);
      OP_SUB:  arg = EW'(opa) - EW'(opb);
      OP_CORR: arg = (EW'(prod) + EW'(keep)) >>> (FB + 1);
      default: arg = '0;
    endcase
    sat = sat_ext(arg);
  end

  assign res = sat.val;
  assign ovf = sat.ovf;

endmodule

>>> rtl/lhi_cfg.sv
// APB configuration registers for the Lorenz Heun integrator.
module lhi_cfg import lhi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [VW-1:0]      pwdata,
  output logic [VW-1:0]      prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma     <= SIGMA_RST;
      cfg.beta      <= BETA_RST;
      cfg.rho       <= RHO_RST;
      cfg.step_size <= STEP_RST;
      cfg.start_x   <= START_X_RST;
      cfg.start_y   <= START_Y_RST;
      cfg.start_z   <= START_Z_RST;
      cfg.method    <= METHOD_HEUN;
    end else if (wr) begin
      case (idx)
        REG_SIGMA:   cfg.sigma     <= pwdata;
        REG_BETA:    cfg.beta      <= pwdata;
        REG_RHO:     cfg.rho       <= pwdata;
        REG_STEP:    cfg.step_size <= pwdata[VW-2:0];
        REG_START_X: cfg.start_x   <= pwdata;
        REG_START_Y: cfg.start_y   <= pwdata;
        REG_START_Z: cfg.start_z   <= pwdata;
        REG_METHOD:  cfg.method    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_SIGMA:   prdata = cfg.sigma;
      REG_BETA:    prdata = cfg.beta;
      REG_RHO:     prdata = cfg.rho;
      REG_STEP:    prdata = {1'b0, cfg.step_size};
      REG_START_X: prdata = cfg.start_x;
      REG_START_Y: prdata = cfg.start_y;
      REG_START_Z: prdata = cfg.start_z;
      REG_METHOD:  prdata = {{(VW-1){1'b0}}, cfg.method};
      default:     prdata = '0;
    endcase
  end

endmodule

>>> rtl/lorenz_heun_integrator.sv
// Lorenz system integrator, Euler or Heun step, on one shared multiplier/adder.
// A step runs the 23-line (Euler) or 46-line (Heun) microcode at one operation a cycle,
// then waits in the finishing state until the output is free; a restart goes straight
// there. The next item is accepted the cycle after the result is loaded. Reset loads
// the configuration registers with their defaults, the position with (0, 0, 25) and
// the step count with 0.
module lorenz_heun_integrator import lhi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [VW-1:0]      pwdata,
  output logic [VW-1:0]      prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output val_t               pos_x,
  output val_t               pos_y,
  output val_t               pos_z,
  output logic [31:0]        step_index,
  output logic               saturated
);

  cfg_t            cfg;
  fsm_t            state, state_next;
  logic [PC_W-1:0] pc;
  uinst_t          uword;

  val_t        cur_x, cur_y, cur_z;
  logic [31:0] step_count, count_next;
  val_t        qx, qy, qz, t0, t1, d0, d1, d2;
  wide_t       keep_q [3];
  logic        flag;
  logic        restarting;

  val_t  opa, opb, alu_res;
  logic  alu_ovf;
  wide_t prod;

  logic take_in, run, commit, out_free, alu_wr, mul_en;

  lhi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign uword = ucode(pc);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) begin
        state_next = restart ? ST_WAIT : ST_RUN;
      end
      ST_RUN:  if (uword.last) begin
        state_next = ST_WAIT;
      end
      ST_WAIT: if (out_free) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    out_free = !out_valid || !out_stall;
    in_stall = (state != ST_IDLE);
    take_in  = in_valid && (state == ST_IDLE);
    run      = (state == ST_RUN);
    commit   = (state == ST_WAIT) && out_free;
    mul_en   = run && (uword.op == OP_MUL);
    alu_wr   = run && (uword.op != OP_MUL);
  end

  // Operand select
  function automatic val_t pick(src_t s, val_t cx, val_t cy, val_t cz, val_t ax, val_t ay,
                                val_t az, val_t u0, val_t u1, val_t e0, val_t e1, val_t e2,
                                cfg_t c);
    val_t v;
    case (s)
      S_CX:    v = cx;
      S_CY:    v = cy;
      S_CZ:    v = cz;
      S_QX:    v = ax;
      S_QY:    v = ay;
      S_QZ:    v = az;
      S_T0:    v = u0;
      S_T1:    v = u1;
      S_D0:    v = e0;
      S_D1:    v = e1;
      S_D2:    v = e2;
      S_SIG:   v = c.sigma;
      S_RHO:   v = c.rho;
      S_BETA:  v = c.beta;
      S_DT:    v = {1'b0, c.step_size};
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opa = pick(uword.sa, cur_x, cur_y, cur_z, qx, qy, qz, t0, t1, d0, d1, d2, cfg);
  assign opb = pick(uword.sb, cur_x, cur_y, cur_z, qx, qy, qz, t0, t1, d0, d1, d2, cfg);

  lhi_alu u_alu (
    .clk    (clk),
    .op     (uword.op),
    .mul_en (mul_en),
    .opa    (opa),
    .opb    (opb),
    .keep   (keep_q[uword.wsel]),
    .res    (alu_res),
    .ovf    (alu_ovf),
    .prod   (prod)
  );

  assign count_next = restarting ? 32'd0 : step_count + 32'd1;

  // Control state, position and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      out_valid  <= 1'b0;
      cur_x      <= START_X_RST;
      cur_y      <= START_Y_RST;
      cur_z      <= START_Z_RST;
      step_count <= '0;
    end else begin
      state <= state_next;
      if (take_in) begin
        pc <= '0;
      end else if (run) begin
        if (uword.branch && cfg.method == METHOD_HEUN) begin
          pc <= PC_W'(HEUN_START);
        end else begin
          pc <= pc + PC_W'(1);
        end
      end
      if (commit) begin
        cur_x      <= qx;
        cur_y      <= qy;
        cur_z      <= qz;
        step_count <= count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      flag       <= 1'b0;
      restarting <= restart;
      if (restart) begin
        qx <= cfg.start_x;
        qy <= cfg.start_y;
        qz <= cfg.start_z;
      end
    end else if (alu_wr) begin
      flag <= flag | alu_ovf;
      case (uword.dst)
        D_QX:    qx <= alu_res;
        D_QY:    qy <= alu_res;
        D_QZ:    qz <= alu_res;
        D_T0:    t0 <= alu_res;
        D_T1:    t1 <= alu_res;
        D_D0:    d0 <= alu_res;
        D_D1:    d1 <= alu_res;
        D_D2:    d2 <= alu_res;
        default: ;
      endcase
      if (uword.keep) begin
        keep_q[uword.wsel] <= prod;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (commit) begin
      pos_x      <= qx;
      pos_y      <= qy;
      pos_z      <= qz;
      step_index <= count_next;
      saturated  <= flag;
    end
  end

  // A new result only ever comes out of the finishing state
  a_result_from_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == ST_WAIT))
    else $error("result loaded outside the finishing state");

  // The sequencer never runs past the end of the microcode
  a_pc_in_rom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (pc < PC_W'(UCODE_DEPTH)))
    else $error("microcode address out of range");

  // The last microcode line hands over to the finishing state
  a_last_to_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && uword.last) |=> (state == ST_WAIT))
    else $error("sequencer missed the end of the step");

endmodule

>>> dv/testbench.sv
// Testbench for lorenz_heun_integrator: queued stimulus, fixed-point trajectory prediction, checks.
module testbench import lhi_pkg::*; ();

  typedef logic signed [127:0] big_t;

  typedef struct {
    val_t        x;
    val_t        y;
    val_t        z;
    logic [31:0] index;
    logic        clamped;
  } point_t;

  localparam big_t VAL_TOP = (big_t'(1) <<< (VW - 1)) - big_t'(1);
  localparam big_t VAL_BOT = -(big_t'(1) <<< (VW - 1));
  localparam val_t ONE     = val_t'(1) <<< FB;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [VW-1:0]      pwdata = '0;
  logic [VW-1:0]      prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  val_t               pos_x;
  val_t               pos_y;
  val_t               pos_z;
  logic [31:0]        step_index;
  logic               saturated;

  lorenz_heun_integrator DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .restart,
    .out_valid, .out_stall, .pos_x, .pos_y, .pos_z, .step_index, .saturated
  );

  // Predictor copy of the registers and the trajectory
  val_t        coef_sigma, coef_beta, coef_rho, init_x, init_y, init_z;
  dt_t         coef_dt;
  logic        heun_on;
  val_t        now_x, now_y, now_z;
  logic [31:0] steps_done;
  bit          clamp_seen;

  logic   queued_items[$];
  point_t expected_points[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int n_reload = 0;
  int n_euler = 0;
  int n_heun = 0;
  int n_clamped = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Saturate an exact value into the Q8.24 range and note any clamp
  function automatic val_t clamp(big_t v);
    if (v > VAL_TOP) begin
      clamp_seen = 1'b1;
      return VAL_TOP[VW-1:0];
    end
    if (v < VAL_BOT) begin
      clamp_seen = 1'b1;
      return VAL_BOT[VW-1:0];
    end
    return v[VW-1:0];
  endfunction

  function automatic val_t fx_add(big_t a, big_t b);
    return clamp(a + b);
  endfunction

  function automatic val_t fx_sub(big_t a, big_t b);
    return clamp(a - b);
  endfunction

  function automatic val_t fx_mul(big_t a, big_t b);
    return clamp((a * b) >>> FB);
  endfunction

  // Lorenz slopes at one point
  function automatic void lorenz_slope(input val_t px, py, pz, output val_t dx, dy, dz);
    dx = fx_mul(coef_sigma, fx_sub(py, px));
    dy = fx_sub(fx_sub(fx_mul(coef_rho, px), fx_mul(px, pz)), py);
    dz = fx_sub(fx_mul(px, py), fx_mul(coef_beta, pz));
  endfunction

  // Heun corrector: half of dt times the summed slopes, from exact products
  function automatic val_t heun_term(val_t d1, val_t d2);
    big_t h, a, b;
    h = coef_dt;
    a = d1;
    b = d2;
    return clamp((h * a + h * b) >>> (FB + 1));
  endfunction

  // Advance the predicted trajectory by one transaction
  function automatic point_t lorenz_advance(logic reload);
    val_t   ax, ay, az, bx, by, bz, qx, qy, qz;
    point_t r;
    clamp_seen = 1'b0;
    if (reload) begin
      now_x = init_x;
      now_y = init_y;
      now_z = init_z;
      steps_done = '0;
    end else begin
      lorenz_slope(now_x, now_y, now_z, ax, ay, az);
      qx = fx_add(now_x, fx_mul(coef_dt, ax));
      qy = fx_add(now_y, fx_mul(coef_dt, ay));
      qz = fx_add(now_z, fx_mul(coef_dt, az));
      if (heun_on == METHOD_HEUN) begin
        lorenz_slope(qx, qy, qz, bx, by, bz);
        qx = fx_add(now_x, heun_term(ax, bx));
        qy = fx_add(now_y, heun_term(ay, by));
        qz = fx_add(now_z, heun_term(az, bz));
      end
      now_x = qx;
      now_y = qy;
      now_z = qz;
      steps_done = steps_done + 32'd1;
    end
    r.x = now_x;
    r.y = now_y;
    r.z = now_z;
    r.index = steps_done;
    r.clamped = clamp_seen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: present queued transactions, predict each one on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (restart) n_reload++;
        else if (heun_on == METHOD_HEUN) n_heun++;
        else n_euler++;
        expected_points = {expected_points, lorenz_advance(restart)};
      end
      if (queued_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        in_valid <= 1'b1;
        restart <= queued_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result, expected none got x=%h y=%h z=%h index=%h",
                   $time, pos_x, pos_y, pos_z, step_index);
          mismatches++;
        end else begin
          e = expected_points.pop_front();
          check_field("pos_x", e.x, pos_x);
          check_field("pos_y", e.y, pos_y);
          check_field("pos_z", e.z, pos_z);
          check_field("step_index", e.index, step_index);
          check_field("saturated", 32'(e.clamped), 32'(saturated));
          if (saturated === 1'b1) n_clamped++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Register write over the APB port; mirror it in the predictor
  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SIGMA:   coef_sigma = value;
      REG_BETA:    coef_beta = value;
      REG_RHO:     coef_rho = value;
      REG_STEP:    coef_dt = value[VW-2:0];
      REG_START_X: init_x = value;
      REG_START_Y: init_y = value;
      REG_START_Z: init_z = value;
      REG_METHOD:  heun_on = value[0];
      default:     ;
    endcase
  endtask

  task automatic queue_steps(int n);
    repeat (n) queued_items = {queued_items, 1'b0};
  endtask

  // Wait until every queued transaction has been answered
  task automatic drain();
    while (queued_items.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Coefficient near a nominal value; in a wild phase also an extreme, zero or a random value
  function automatic val_t pick_coef(val_t nominal, bit wild);
    val_t jitter;
    jitter = val_t'($urandom_range(0, 32'h0400_0000)) - val_t'(32'h0200_0000);
    if (!wild) return nominal + jitter;
    case ($urandom_range(0, 9))
      0:       return MAX_V;
      1:       return MIN_V;
      2:       return '0;
      3, 4:    return val_t'($urandom);
      default: return nominal + jitter;
    endcase
  endfunction

  function automatic dt_t pick_dt(bit wild);
    if (wild) begin
      case ($urandom_range(0, 5))
        0:       return '1;
        1:       return '0;
        2:       return dt_t'($urandom);
        default: ;
      endcase
    end
    return dt_t'($urandom_range(1, 335544));
  endfunction

  // Stimulus: directed checks, then random phases over configs and idling
  initial begin
    bit   wild;
    val_t centre;
    coef_sigma = SIGMA_RST;
    coef_beta = BETA_RST;
    coef_rho = RHO_RST;
    coef_dt = STEP_RST;
    init_x = START_X_RST;
    init_y = START_Y_RST;
    init_z = START_Z_RST;
    heun_on = METHOD_HEUN;
    now_x = START_X_RST;
    now_y = START_Y_RST;
    now_z = START_Z_RST;
    steps_done = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // steps from the reset point with default Heun, then a reload, then Euler steps
    queue_steps(3);
    queued_items = {queued_items, 1'b1};
    queue_steps(1);
    drain();
    apb_write(REG_METHOD, 32'(METHOD_EULER));
    queue_steps(2);
    drain();

    // new start values wait for the next reload
    apb_write(REG_START_X, ONE);
    apb_write(REG_START_Y, -2 * ONE);
    queue_steps(1);
    queued_items = {queued_items, 1'b1};
    queue_steps(1);
    drain();

    // drive every intermediate into saturation
    apb_write(REG_SIGMA, MAX_V);
    apb_write(REG_BETA, MAX_V);
    apb_write(REG_RHO, MIN_V);
    apb_write(REG_STEP, 32'h7fff_ffff);
    apb_write(REG_START_X, MAX_V);
    apb_write(REG_START_Y, MIN_V);
    apb_write(REG_START_Z, MIN_V);
    queued_items = {queued_items, 1'b1};
    queue_steps(2);
    drain();
    apb_write(REG_METHOD, 32'(METHOD_HEUN));
    queue_steps(2);
    drain();
    apb_write(REG_STEP, 32'd0);
    queue_steps(1);
    drain();

    // opposite extremes with the smallest nonzero step
    apb_write(REG_SIGMA, MIN_V);
    apb_write(REG_BETA, MIN_V);
    apb_write(REG_RHO, MAX_V);
    apb_write(REG_STEP, 32'd1);
    apb_write(REG_START_X, MIN_V);
    apb_write(REG_START_Y, MAX_V);
    apb_write(REG_START_Z, MAX_V);
    queued_items = {queued_items, 1'b1};
    queue_steps(2);
    drain();

    // random phases: reload then long runs of steps, occasional reloads
    for (int p = 0; p < 12; p++) begin
      wild = (p % 3 == 2);
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 60; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase
      apb_write(REG_SIGMA, pick_coef(SIGMA_RST, wild));
      apb_write(REG_BETA, pick_coef(BETA_RST, wild));
      apb_write(REG_RHO, pick_coef(val_t'(28) * ONE, wild));
      apb_write(REG_STEP, 32'(pick_dt(wild)));
      for (int k = 0; k < 3; k++) begin
        centre = val_t'($urandom_range(0, 32'h2000_0000)) - val_t'(32'h1000_0000);
        apb_write(reg_idx_t'(REG_START_X + k), pick_coef(centre, wild));
      end
      apb_write(REG_METHOD, $urandom_range(0, 1));
      queued_items = {queued_items, 1'b1};
      repeat (107) queued_items = {queued_items, ($urandom_range(0, 99) < 4)};
      drain();
    end

    repeat (60) @(posedge clk);
    $display("Covered %0d reloads, %0d Euler and %0d Heun steps over directed and 12 random phases",
             n_reload, n_euler, n_heun);
    $display("%0d results carried the saturation flag", n_clamped);
    if (mismatches == 0) begin
      $display("[lorenz_heun_integrator] OK");
    end else begin
      $display("[lorenz_heun_integrator] ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #6000000;
    $display("[lorenz_heun_integrator] ERROR");
    $finish;
  end

endmodule

>>> lorenz_heun_integrator.f
rtl/lhi_pkg.sv
rtl/lhi_alu.sv
rtl/lhi_cfg.sv
rtl/lorenz_heun_integrator.sv
dv/testbench.sv
